/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// widths, pipeline lane type and helpers of the rgb/hsb converter
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int CB           = CHANNEL_BITS;
  // divider remainder width, holds six times a channel difference
  localparam int REM_BITS     = CB + 3;
  localparam int DIV_STAGES   = CB;
  localparam int FRONT_STAGES = 3;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [CB-1:0] FULL_SCALE = {CB{1'b1}};

  localparam logic KIND_TO_HSB = 1'b0;
  localparam logic KIND_TO_RGB = 1'b1;

  typedef logic [CB-1:0] chan_t;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  // hue sectors of the rgb rebuild
  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;

  typedef struct packed {
    logic [REM_BITS-1:0] den;
    logic [REM_BITS-1:0] rem;
    chan_t               low;
    chan_t               quo;
  } div_t;

  typedef struct packed {
    logic  kind;
    div_t  hue;
    div_t  sat;
    logic  hue_zero;
    logic  sat_zero;
    chan_t ra;
    chan_t rb;
    chan_t rc;
  } lane_t;

  // floor(x / FULL_SCALE) by reciprocal: (y + (y >> CB)) >> CB with y = x + 1
  function automatic chan_t div_full_scale(logic [2*CB-1:0] x);
    logic [2*CB:0] y;
    logic [2*CB:0] sum;
    y   = {1'b0, x} + (2*CB+1)'(1);
    sum = y + (y >> CB);
    return sum[2*CB-1:CB];
  endfunction

endpackage

/* hw/rtl/rhc_in_if.sv */
// ----------------------------------------------------------------------------
// rhc_in_if
// input pixel channel: valid/ready with kind and three channels
// ----------------------------------------------------------------------------
interface rhc_in_if;
  logic           valid;
  logic           ready;
  logic           kind;
  rhc_pkg::chan_t chan_a;
  rhc_pkg::chan_t chan_b;
  rhc_pkg::chan_t chan_c;

  modport source (output valid, kind, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, kind, chan_a, chan_b, chan_c, output ready);
endinterface

/* hw/rtl/rhc_out_if.sv */
// ----------------------------------------------------------------------------
// rhc_out_if
// result pixel channel: valid/ready with three result channels
// ----------------------------------------------------------------------------
interface rhc_out_if;
  logic           valid;
  logic           ready;
  rhc_pkg::chan_t res_a;
  rhc_pkg::chan_t res_b;
  rhc_pkg::chan_t res_c;

  modport source (output valid, res_a, res_b, res_c, input ready);
  modport sink   (input valid, res_a, res_b, res_c, output ready);
endinterface

/* hw/rtl/rhc_front.sv */
// ----------------------------------------------------------------------------
// rhc_front
// three stage front end: max/min and hue numerator for rgb input, full
// p/q/t rebuild for hsb input, divider setup
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic                  clk,
  input  logic                  adv,
  input  logic                  kind,
  input  rhc_pkg::chan_t        chan_a,
  input  rhc_pkg::chan_t        chan_b,
  input  rhc_pkg::chan_t        chan_c,
  output rhc_pkg::lane_t        lane
);

  localparam int CB = rhc_pkg::CB;
  localparam int RW = rhc_pkg::REM_BITS;

  // stage 1
  logic               k1;
  rhc_pkg::chan_t     a1, b1, c1, mx1, mn1, aq1, at1;
  rhc_pkg::max_sel_t  sel1;
  logic [2:0]         sec1;

  rhc_pkg::chan_t     mx_c, mn_c;
  rhc_pkg::max_sel_t  sel_c;
  logic [CB+2:0]      x6;
  logic [CB:0]        tf;
  logic [2*CB-1:0]    sf;
  logic [2*CB:0]      st;

  always_comb begin
    if (chan_a >= chan_b && chan_a >= chan_c) begin
      sel_c = rhc_pkg::SEL_RED;
      mx_c  = chan_a;
    end else if (chan_b >= chan_c) begin
      sel_c = rhc_pkg::SEL_GREEN;
      mx_c  = chan_b;
    end else begin
      sel_c = rhc_pkg::SEL_BLUE;
      mx_c  = chan_c;
    end
    mn_c = chan_a;
    if (chan_b < mn_c) mn_c = chan_b;
    if (chan_c < mn_c) mn_c = chan_c;
    // hue times six splits into sector and fraction
    x6 = ({3'b000, chan_a} << 2) + ({3'b000, chan_a} << 1);
    tf = {1'b1, {CB{1'b0}}} - {1'b0, x6[CB-1:0]};
    sf = (2*CB)'(chan_b) * (2*CB)'(x6[CB-1:0]);
    st = (2*CB+1)'(chan_b) * (2*CB+1)'(tf);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1   <= kind;
      a1   <= chan_a;
      b1   <= chan_b;
      c1   <= chan_c;
      mx1  <= mx_c;
      mn1  <= mn_c;
      sel1 <= sel_c;
      sec1 <= x6[CB+2:CB];
      aq1  <= sf[2*CB-1:CB];
      at1  <= st[2*CB-1:CB];
    end
  end

  // stage 2
  logic               k2, sz2;
  rhc_pkg::chan_t     mx2, d2, v2;
  logic [RW-1:0]      num2;
  logic [2*CB-1:0]    dm2, pp2, pq2, pt2;
  logic [2:0]         sec2;

  rhc_pkg::chan_t     d_c;
  logic [RW-1:0]      d6_c, num_c;

  always_comb begin
    d_c  = mx1 - mn1;
    d6_c = (RW'(d_c) << 2) + (RW'(d_c) << 1);
    case (sel1)
      rhc_pkg::SEL_RED: begin
        if (b1 >= c1) num_c = RW'(b1 - c1);
        else          num_c = d6_c - RW'(c1 - b1);
      end
      rhc_pkg::SEL_GREEN: num_c = (RW'(d_c) << 1) + RW'(c1) - RW'(a1);
      rhc_pkg::SEL_BLUE:  num_c = (RW'(d_c) << 2) + RW'(a1) - RW'(b1);
      default:            num_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2   <= k1;
      sz2  <= (b1 == '0);
      mx2  <= mx1;
      d2   <= d_c;
      v2   <= c1;
      num2 <= num_c;
      dm2  <= {d_c, {CB{1'b0}}} - (2*CB)'(d_c);
      pp2  <= (2*CB)'(c1) * (2*CB)'(rhc_pkg::FULL_SCALE - b1);
      pq2  <= (2*CB)'(c1) * (2*CB)'(rhc_pkg::FULL_SCALE - aq1);
      pt2  <= (2*CB)'(c1) * (2*CB)'(rhc_pkg::FULL_SCALE - at1);
      sec2 <= sec1;
    end
  end

  // stage 3
  rhc_pkg::lane_t lane_c;
  rhc_pkg::chan_t p_c, q_c, t_c;

  always_comb begin
    p_c = rhc_pkg::div_full_scale(pp2);
    q_c = rhc_pkg::div_full_scale(pq2);
    t_c = rhc_pkg::div_full_scale(pt2);

    lane_c.kind     = k2;
    lane_c.hue.den  = (RW'(d2) << 2) + (RW'(d2) << 1);
    lane_c.hue.rem  = num2;
    lane_c.hue.low  = '0;
    lane_c.hue.quo  = '0;
    lane_c.sat.den  = RW'(mx2);
    lane_c.sat.rem  = RW'(dm2[2*CB-1:CB]);
    lane_c.sat.low  = dm2[CB-1:0];
    lane_c.sat.quo  = '0;
    lane_c.hue_zero = (d2 == '0);
    lane_c.sat_zero = (mx2 == '0);

    if (k2 == rhc_pkg::KIND_TO_HSB) begin
      lane_c.ra = '0;
      lane_c.rb = '0;
      lane_c.rc = mx2;
    end else if (sz2) begin
      // no saturation: grey at the given brightness
      lane_c.ra = v2;
      lane_c.rb = v2;
      lane_c.rc = v2;
    end else begin
      case (sec2)
        rhc_pkg::SECTOR_0: begin lane_c.ra = v2;  lane_c.rb = t_c; lane_c.rc = p_c; end
        rhc_pkg::SECTOR_1: begin lane_c.ra = q_c; lane_c.rb = v2;  lane_c.rc = p_c; end
        rhc_pkg::SECTOR_2: begin lane_c.ra = p_c; lane_c.rb = v2;  lane_c.rc = t_c; end
        rhc_pkg::SECTOR_3: begin lane_c.ra = p_c; lane_c.rb = q_c; lane_c.rc = v2;  end
        rhc_pkg::SECTOR_4: begin lane_c.ra = t_c; lane_c.rb = p_c; lane_c.rc = v2;  end
        default:           begin lane_c.ra = v2;  lane_c.rb = p_c; lane_c.rc = q_c; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane <= lane_c;
    end
  end

endmodule

/* hw/rtl/rhc_div_stage.sv */
// ----------------------------------------------------------------------------
// rhc_div_stage
// one registered restoring step for both the hue and saturation quotients
// ----------------------------------------------------------------------------
module rhc_div_stage (
  input  logic           clk,
  input  logic           adv,
  input  rhc_pkg::lane_t lane_in,
  output rhc_pkg::lane_t lane_out
);

  localparam int CB = rhc_pkg::CB;
  localparam int RW = rhc_pkg::REM_BITS;

  function automatic rhc_pkg::div_t div_step(rhc_pkg::div_t s);
    rhc_pkg::div_t  o;
    logic [RW:0]    r2;
    logic           ge;
    r2     = {s.rem, s.low[CB-1]};
    ge     = (r2 >= {1'b0, s.den});
    o.den  = s.den;
    o.rem  = ge ? RW'(r2 - {1'b0, s.den}) : RW'(r2);
    o.low  = {s.low[CB-2:0], 1'b0};
    o.quo  = {s.quo[CB-2:0], ge};
    return o;
  endfunction

  rhc_pkg::lane_t lane_c;

  always_comb begin
    lane_c     = lane_in;
    lane_c.hue = div_step(lane_in.hue);
    lane_c.sat = div_step(lane_in.sat);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_out <= lane_c;
    end
  end

endmodule

/* hw/rtl/rgb_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_hsv_converter
// streaming rgb <-> hsb color converter, while not stalled one pixel per clock
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the line is not stalled and returns one
// result per pixel, in order, once it has passed every pipeline register.
// kind 0 turns red/green/blue into hue/saturation/brightness, kind 1 goes the
// other way; both kinds may be mixed freely in the stream. Three front stages
// find max/min and the hue numerator (or build p, q, t and pick the sector),
// then a line of CHANNEL_BITS restoring-division stages produces one quotient
// bit per stage for hue and saturation in parallel, and a final output
// register drives the result channel. The whole line advances together: it
// moves whenever the output register is empty or its result is taken, so a
// held result stalls every stage without loss and input ready follows output
// ready one for one while a result is held. Hue is a fraction of one turn and
// wraps; divisions truncate; black gives saturation 0 and grey gives hue 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_hsv_converter (
  input logic       clk,
  input logic       rst,
  rhc_in_if.sink    pix_in,
  rhc_out_if.source pix_out
);

  localparam int CB   = rhc_pkg::CB;
  localparam int NST  = rhc_pkg::NUM_STAGES;
  localparam int LAST = NST - 1;

  // one valid bit per pipeline stage; the last one is the output register
  logic [NST-1:0] vld;
  logic           adv;

  // the line moves when the output slot is free or being emptied
  assign adv          = !vld[LAST] || pix_out.ready;
  assign pix_in.ready = adv;
  assign pix_out.valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], pix_in.valid};
    end
  end

  // front end: min/max, numerators, p/q/t rebuild
  rhc_pkg::lane_t dl [0:CB];

  rhc_front u_front (
    .clk    (clk),
    .adv    (adv),
    .kind   (pix_in.kind),
    .chan_a (pix_in.chan_a),
    .chan_b (pix_in.chan_b),
    .chan_c (pix_in.chan_c),
    .lane   (dl[0])
  );

  // one quotient bit per stage
  for (genvar i = 0; i < CB; i++) begin : g_div
    rhc_div_stage u_div (
      .clk      (clk),
      .adv      (adv),
      .lane_in  (dl[i]),
      .lane_out (dl[i+1])
    );
  end

  // output register: pick quotients or rebuilt rgb, force black/grey cases
  rhc_pkg::chan_t res_a, res_b, res_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dl[CB].kind == rhc_pkg::KIND_TO_HSB) begin
        res_a <= dl[CB].hue_zero ? '0 : dl[CB].hue.quo;
        res_b <= dl[CB].sat_zero ? '0 : dl[CB].sat.quo;
        res_c <= dl[CB].rc;
      end else begin
        res_a <= dl[CB].ra;
        res_b <= dl[CB].rb;
        res_c <= dl[CB].rc;
      end
    end
  end

  assign pix_out.res_a = res_a;
  assign pix_out.res_b = res_b;
  assign pix_out.res_c = res_c;

  // an input transfer always lands in the first stage
  `ASSERT_NEXT(a_enter, pix_in.valid && pix_in.ready, vld[0], "transfer not captured")
  // a stalled line keeps every valid bit where it was
  `ASSERT_NEXT(a_hold, !adv, $stable(vld), "valid bits moved during stall")
  // a held result blocks the input side
  `ASSERT_IMPL(a_block, vld[LAST] && !pix_out.ready, !pix_in.ready, "input open while full")

endmodule
